// ----- rtl/pfc_pkg.sv -----
// Package for the pose frame converter: payload types, constants and
// the fixed-point helpers for rounding, saturation and the frame rotations.
// No dependencies.
package pfc_pkg;

  localparam int LOC_W  = 32;
  localparam int QUAT_W = 18;

  localparam logic signed [QUAT_W-1:0] Q_MAX = 18'sd131071;
  localparam logic signed [QUAT_W-1:0] Q_MIN = -18'sd131072;

  // Config register indexes
  localparam logic CFG_SOURCE_RUNTIME = 1'b0;
  localparam logic CFG_TARGET_FRAME   = 1'b1;

  // Runtime codes and frame codes
  localparam logic [1:0] RT_A    = 2'd0;
  localparam logic [1:0] RT_B    = 2'd1;
  localparam logic [1:0] RT_OPEN = 2'd2;
  localparam logic [1:0] RT_ALT  = 2'd3;   // unused code, read as open runtime

  localparam logic [2:0] FRAME_FOREIGN_FIRST = 3'd3;
  localparam logic [2:0] FRAME_FOREIGN_LAST  = 3'd5;

  localparam logic DEV_CONTROLLER = 1'b1;

  // floor(n / 100) == (n * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit n
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int          DIV100_SHIFT = 37;
  localparam logic [31:0] DIV100_HALF  = 32'd50;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [LOC_W-1:0] x;
    logic signed [LOC_W-1:0] y;
    logic signed [LOC_W-1:0] z;
  } loc_t;

  typedef struct packed {
    logic                     foreign;
    logic                     has_corr;
    logic signed [QUAT_W-1:0] c_sin;
    logic signed [QUAT_W-1:0] c_cos;
  } ctl_t;

  // Y-axis correction, sin of half angle, indexed by source and target runtime
  function automatic logic signed [QUAT_W-1:0] corr_sin(input logic [1:0] src,
                                                        input logic [1:0] tr);
    logic signed [QUAT_W-1:0] r;
    case ({src, tr})
      {RT_A, RT_B}:    r = -18'sd14185;
      {RT_A, RT_OPEN}: r = -18'sd30261;
      {RT_B, RT_A}:    r = 18'sd14185;
      {RT_B, RT_OPEN}: r = -18'sd16962;
      {RT_OPEN, RT_A}: r = 18'sd30261;
      {RT_OPEN, RT_B}: r = 18'sd16962;
      default:         r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [QUAT_W-1:0] corr_cos(input logic [1:0] src,
                                                        input logic [1:0] tr);
    logic signed [QUAT_W-1:0] r;
    case ({src, tr})
      {RT_A, RT_B}, {RT_B, RT_A}:       r = 18'sd63983;
      {RT_A, RT_OPEN}, {RT_OPEN, RT_A}: r = 18'sd58131;
      {RT_B, RT_OPEN}, {RT_OPEN, RT_B}: r = 18'sd63303;
      default:                          r = 18'sd65536;
    endcase
    return r;
  endfunction

  // s / 2 rounded half away from zero, saturated to Q2.16
  function automatic logic signed [QUAT_W-1:0] half_sat(input logic signed [20:0] s);
    logic [20:0] mag;
    logic [20:0] r;
    logic signed [QUAT_W-1:0] res;
    mag = s[20] ? 21'(-s) : 21'(s);
    r   = (mag + 21'd1) >> 1;
    if (!s[20]) begin
      res = (r > 21'd131071) ? Q_MAX : QUAT_W'(r);
    end else begin
      res = (r > 21'd131072) ? Q_MIN : QUAT_W'(21'd0 - r);
    end
    return res;
  endfunction

  // s >> 16 rounded half away from zero, saturated to Q2.16
  function automatic logic signed [QUAT_W-1:0] q16_sat(input logic signed [37:0] s);
    logic [37:0] mag;
    logic [37:0] r;
    logic signed [QUAT_W-1:0] res;
    mag = s[37] ? 38'(-s) : 38'(s);
    r   = (mag + 38'd32768) >> 16;
    if (!s[37]) begin
      res = (r > 38'd131071) ? Q_MAX : QUAT_W'(r);
    end else begin
      res = (r > 38'd131072) ? Q_MIN : QUAT_W'(38'd0 - r);
    end
    return res;
  endfunction

  // (-0.5,-0.5,-0.5,0.5) * b; every term is +-0.5 * b, so the product is a sum
  function automatic quat_t lxyz_mul(input quat_t b);
    logic signed [20:0] bx, by, bz, bw;
    quat_t r;
    bx = 21'(b.x);
    by = 21'(b.y);
    bz = 21'(b.z);
    bw = 21'(b.w);
    r.w = half_sat(bw + bx + by + bz);
    r.x = half_sat(bx - bw - bz + by);
    r.y = half_sat(by + bz - bw - bx);
    r.z = half_sat(bz - by + bx - bw);
    return r;
  endfunction

  // a * (0.5,0.5,0.5,0.5)
  function automatic quat_t lxzy_mul(input quat_t a);
    logic signed [20:0] ax, ay, az, aw;
    quat_t r;
    ax = 21'(a.x);
    ay = 21'(a.y);
    az = 21'(a.z);
    aw = 21'(a.w);
    r.w = half_sat(aw - ax - ay - az);
    r.x = half_sat(aw + ax + ay - az);
    r.y = half_sat(aw - ax + ay + az);
    r.z = half_sat(aw + ax - ay + az);
    return r;
  endfunction

endpackage

// ----- rtl/pfc_cfg_if.sv -----
// Configuration write channel: register index and write data.
// No dependencies.
interface pfc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [2:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/pfc_pose_if.sv -----
// Input pose channel: location, orientation and device kind of one item.
// No dependencies.
interface pfc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] loc_x;
  logic signed [31:0] loc_y;
  logic signed [31:0] loc_z;
  logic signed [17:0] rot_x;
  logic signed [17:0] rot_y;
  logic signed [17:0] rot_z;
  logic signed [17:0] rot_w;
  logic               device_kind;

  modport source(output valid, output loc_x, output loc_y, output loc_z,
                 output rot_x, output rot_y, output rot_z, output rot_w,
                 output device_kind, input ready);
  modport sink(input valid, input loc_x, input loc_y, input loc_z,
               input rot_x, input rot_y, input rot_z, input rot_w,
               input device_kind, output ready);
endinterface

// ----- rtl/pfc_result_if.sv -----
// Output channel: converted position and quaternion of one item.
// No dependencies.
interface pfc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_0;
  logic signed [31:0] pos_1;
  logic signed [31:0] pos_2;
  logic signed [17:0] quat_x;
  logic signed [17:0] quat_y;
  logic signed [17:0] quat_z;
  logic signed [17:0] quat_w;

  modport source(output valid, output pos_0, output pos_1, output pos_2,
                 output quat_x, output quat_y, output quat_z, output quat_w,
                 input ready);
  modport sink(input valid, input pos_0, input pos_1, input pos_2,
               input quat_x, input quat_y, input quat_z, input quat_w,
               output ready);
endinterface

// ----- rtl/pfc_corr_mult.sv -----
// Right product with the Y-axis correction quaternion (0, s, 0, c):
// one stage of eight 18x18 multipliers, one stage of add, round and saturate.
// Depends on pfc_pkg.
module pfc_corr_mult
  import pfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     ld_mul,
  input  logic                     ld_sum,
  input  quat_t                    q_in,
  input  logic                     has_corr_in,
  input  logic signed [QUAT_W-1:0] c_sin,
  input  logic signed [QUAT_W-1:0] c_cos,
  output quat_t                    q_out
);

  logic signed [35:0] p_wc, p_ys, p_xc, p_zs, p_ws, p_yc, p_xs, p_zc;
  quat_t              q_d;
  logic               has_corr_d;
  quat_t              q_corr;

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      p_wc       <= q_in.w * c_cos;
      p_ys       <= q_in.y * c_sin;
      p_xc       <= q_in.x * c_cos;
      p_zs       <= q_in.z * c_sin;
      p_ws       <= q_in.w * c_sin;
      p_yc       <= q_in.y * c_cos;
      p_xs       <= q_in.x * c_sin;
      p_zc       <= q_in.z * c_cos;
      q_d        <= q_in;
      has_corr_d <= has_corr_in;
    end
  end

  always_comb begin
    q_corr.w = q16_sat(38'(p_wc) - 38'(p_ys));
    q_corr.x = q16_sat(38'(p_xc) - 38'(p_zs));
    q_corr.y = q16_sat(38'(p_ws) + 38'(p_yc));
    q_corr.z = q16_sat(38'(p_xs) + 38'(p_zc));
  end

  always_ff @(posedge clk) begin
    if (ld_sum) begin
      q_out <= has_corr_d ? q_corr : q_d;
    end
  end

endmodule

// ----- rtl/pfc_loc_scale.sv -----
// Location path: magnitude, reciprocal multiply for the rounded /100,
// sign restore and axis permutation for foreign frames. Three register stages.
// Depends on pfc_pkg.
module pfc_loc_scale
  import pfc_pkg::*;
(
  input  logic clk,
  input  logic ld_abs,
  input  logic ld_mul,
  input  logic ld_out,
  input  loc_t loc_in,
  input  logic foreign_in,
  output loc_t pos_out
);

  logic signed [LOC_W-1:0] lane_in [3];
  logic [LOC_W-1:0]        n_a     [3];
  logic [2:0]              neg_a, neg_b;
  loc_t                    raw_a, raw_b;
  logic                    foreign_a, foreign_b;
  logic [63:0]             prod_b  [3];
  logic signed [LOC_W-1:0] div_c   [3];

  assign lane_in[0] = loc_in.x;
  assign lane_in[1] = loc_in.y;
  assign lane_in[2] = loc_in.z;

  // |v| + 50 always fits 32 bits unsigned, including for the most negative v
  always_ff @(posedge clk) begin
    if (ld_abs) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= lane_in[i][LOC_W-1];
        n_a[i]   <= (lane_in[i][LOC_W-1] ? LOC_W'(-lane_in[i]) : LOC_W'(lane_in[i]))
                    + DIV100_HALF;
      end
      raw_a     <= loc_in;
      foreign_a <= foreign_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      for (int i = 0; i < 3; i++) begin
        prod_b[i] <= {32'd0, n_a[i]} * {32'd0, DIV100_MAGIC};
      end
      neg_b     <= neg_a;
      raw_b     <= raw_a;
      foreign_b <= foreign_a;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_c[i] = neg_b[i] ? LOC_W'(32'd0 - LOC_W'(prod_b[i][63:DIV100_SHIFT]))
                          : LOC_W'(prod_b[i][63:DIV100_SHIFT]);
    end
  end

  // foreign frames take (Y, Z, X)
  always_ff @(posedge clk) begin
    if (ld_out) begin
      if (foreign_b) begin
        pos_out.x <= div_c[1];
        pos_out.y <= div_c[2];
        pos_out.z <= div_c[0];
      end else begin
        pos_out <= raw_b;
      end
    end
  end

endmodule

// ----- rtl/pose_frame_convert_in_core.sv -----
// Pose frame converter, top level: config registers, input decode, the
// frame rotation stages and the output register around the two datapaths.
// Depends on pfc_pkg, the three channel interfaces, pfc_corr_mult, pfc_loc_scale.
//
// Converts one tracked pose per item from the source runtime's frame into
// the selected target frame. Fully pipelined: one item per clock unless the
// output stalls, through five register stages (input register, left frame
// rotation, correction multiply, correction sum and /100, right frame rotation
// into the output register). Each stage advances as soon as the one after it
// has room, so bubbles collapse and the input keeps flowing while a finished
// result waits at the output, until the stages behind it are full. Config
// writes are always taken and apply to items accepted afterwards.
module pose_frame_convert_in_core
  import pfc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  pfc_cfg_if.sink      cfg,
  pfc_pose_if.sink     pose,
  pfc_result_if.source result
);

  logic [1:0] source_runtime;
  logic [2:0] target_frame;

  logic [1:0] src, tr;
  ctl_t       ctl_in;

  logic v1, v2, v3, v4, vo;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;

  quat_t q1, q2, q4;
  loc_t  loc1, pos4;
  ctl_t  ctl1, ctl2;
  logic  f3, f4;
  quat_t q_fin;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_runtime <= RT_A;
      target_frame   <= 3'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SOURCE_RUNTIME: source_runtime <= cfg.data[1:0];
        CFG_TARGET_FRAME:   target_frame   <= cfg.data;
      endcase
    end
  end

  // decode of the frame selection
  always_comb begin
    src = (source_runtime == RT_ALT) ? RT_OPEN : source_runtime;
    ctl_in.foreign = (target_frame >= FRAME_FOREIGN_FIRST);
    tr  = ctl_in.foreign ? 2'(target_frame - FRAME_FOREIGN_FIRST) : target_frame[1:0];
    // frames beyond the last foreign one never take a correction
    ctl_in.has_corr = (target_frame <= FRAME_FOREIGN_LAST)
                      && (pose.device_kind == DEV_CONTROLLER) && (tr != src);
    ctl_in.c_sin = corr_sin(src, tr);
    ctl_in.c_cos = corr_cos(src, tr);
  end

  // stage handshake
  assign rdy_o = !vo || result.ready;
  assign rdy4  = !v4 || rdy_o;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign pose.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1)  v1 <= pose.valid;
      if (rdy2)  v2 <= v1;
      if (rdy3)  v3 <= v2;
      if (rdy4)  v4 <= v3;
      if (rdy_o) vo <= v4;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      q1.x   <= pose.rot_x;
      q1.y   <= pose.rot_y;
      q1.z   <= pose.rot_z;
      q1.w   <= pose.rot_w;
      loc1.x <= pose.loc_x;
      loc1.y <= pose.loc_y;
      loc1.z <= pose.loc_z;
      ctl1   <= ctl_in;
    end
  end

  // left frame rotation
  always_ff @(posedge clk) begin
    if (rdy2) begin
      q2   <= ctl1.foreign ? lxyz_mul(q1) : q1;
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) f3 <= ctl2.foreign;
    if (rdy4) f4 <= f3;
  end

  pfc_corr_mult u_corr (
    .clk         (clk),
    .ld_mul      (rdy3),
    .ld_sum      (rdy4),
    .q_in        (q2),
    .has_corr_in (ctl2.has_corr),
    .c_sin       (ctl2.c_sin),
    .c_cos       (ctl2.c_cos),
    .q_out       (q4)
  );

  pfc_loc_scale u_loc (
    .clk        (clk),
    .ld_abs     (rdy2),
    .ld_mul     (rdy3),
    .ld_out     (rdy4),
    .loc_in     (loc1),
    .foreign_in (ctl1.foreign),
    .pos_out    (pos4)
  );

  // right frame rotation into the output register
  assign q_fin = f4 ? lxzy_mul(q4) : q4;

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      result.pos_0  <= pos4.x;
      result.pos_1  <= pos4.y;
      result.pos_2  <= pos4.z;
      result.quat_x <= q_fin.x;
      result.quat_y <= q_fin.y;
      result.quat_z <= q_fin.z;
      result.quat_w <= q_fin.w;
    end
  end

  assign result.valid = vo;

endmodule

// ----- test/testbench.sv -----
// Testbench for pose_frame_convert_in_core: drives poses under every runtime and frame setting,
// predicts each converted pose in a scoreboard class and checks every result field.
// Depends on pfc_pkg, pfc_cfg_if, pfc_pose_if, pfc_result_if and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import pfc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 14;

  typedef struct {
    loc_t  loc;
    quat_t rot;
    logic  dev;
  } pose_item_t;

  typedef struct {
    loc_t  pos;
    quat_t quat;
  } pose_result_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
    longint w;
  } wide_quat_t;

  class pose_scoreboard;
    logic [1:0]   src_reg;
    logic [2:0]   frame_reg;
    pose_result_t pending_poses[$];
    int           errors;

    function new();
      src_reg   = RT_A;
      frame_reg = 3'd0;
      errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [2:0] data);
      if (idx == CFG_SOURCE_RUNTIME) begin
        src_reg = data[1:0];
      end else begin
        frame_reg = data;
      end
    endfunction

    // Q2.16 product sum back to Q2.16, ties away from zero, then clamp
    function longint round_clamp(longint v);
      longint r;
      r = (v >= 0) ? ((v + 32768) >>> 16) : -(((-v) + 32768) >>> 16);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r;
    endfunction

    // cm to m in Q16.16, ties away from zero
    function longint centi(longint v);
      return (v >= 0) ? ((v + 50) / 100) : -(((-v) + 50) / 100);
    endfunction

    function wide_quat_t hamilton(wide_quat_t a, wide_quat_t b);
      wide_quat_t r;
      r.w = round_clamp(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
      r.x = round_clamp(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
      r.y = round_clamp(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
      r.z = round_clamp(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
      return r;
    endfunction

    // controller convention fix: rotation about Y between runtimes
    function wide_quat_t yaw_fix(logic [1:0] src, logic [1:0] tr);
      wide_quat_t c;
      c = '{x: 0, y: 0, z: 0, w: 65536};
      case ({src, tr})
        {RT_A, RT_B}:    begin c.y = -14185; c.w = 63983; end
        {RT_A, RT_OPEN}: begin c.y = -30261; c.w = 58131; end
        {RT_B, RT_A}:    begin c.y = 14185;  c.w = 63983; end
        {RT_B, RT_OPEN}: begin c.y = -16962; c.w = 63303; end
        {RT_OPEN, RT_A}: begin c.y = 30261;  c.w = 58131; end
        {RT_OPEN, RT_B}: begin c.y = 16962;  c.w = 63303; end
        default:         c.w = 65536;
      endcase
      return c;
    endfunction

    function pose_result_t convert(pose_item_t p);
      wide_quat_t   q, c, lxyz, lxzy;
      logic [1:0]   src, tr;
      logic [2:0]   tf;
      bit           corr;
      pose_result_t r;
      src  = (src_reg == RT_ALT) ? RT_OPEN : src_reg;
      tf   = frame_reg;
      corr = 0;
      q    = '{x: p.rot.x, y: p.rot.y, z: p.rot.z, w: p.rot.w};
      // frames past the last foreign one get no correction at all
      if (tf <= FRAME_FOREIGN_LAST && p.dev == DEV_CONTROLLER) begin
        tr = (tf < FRAME_FOREIGN_FIRST) ? tf[1:0] : 2'(tf - FRAME_FOREIGN_FIRST);
        if (tr != src) begin
          corr = 1;
          c = yaw_fix(src, tr);
        end
      end
      if (tf < FRAME_FOREIGN_FIRST) begin
        r.pos = p.loc;
        if (corr) q = hamilton(q, c);
      end else begin
        r.pos.x = 32'(centi(p.loc.y));
        r.pos.y = 32'(centi(p.loc.z));
        r.pos.z = 32'(centi(p.loc.x));
        lxyz = '{x: -32768, y: -32768, z: -32768, w: 32768};
        lxzy = '{x: 32768, y: 32768, z: 32768, w: 32768};
        q = hamilton(lxyz, q);
        if (corr) q = hamilton(q, c);
        q = hamilton(q, lxzy);
      end
      r.quat.x = 18'(q.x);
      r.quat.y = 18'(q.y);
      r.quat.z = 18'(q.z);
      r.quat.w = 18'(q.w);
      return r;
    endfunction

    function void note_pose(pose_item_t p);
      pending_poses.push_back(convert(p));
    endfunction

    function int pending();
      return pending_poses.size();
    endfunction

    function void fields(pose_result_t r, output longint f[7]);
      f[0] = r.pos.x;
      f[1] = r.pos.y;
      f[2] = r.pos.z;
      f[3] = r.quat.x;
      f[4] = r.quat.y;
      f[5] = r.quat.z;
      f[6] = r.quat.w;
    endfunction

    task report(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task check(pose_result_t got);
      pose_result_t want;
      longint       gf[7], wf[7];
      string        names[7];
      names = '{"pos_0", "pos_1", "pos_2", "quat_x", "quat_y", "quat_z", "quat_w"};
      if (pending_poses.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending_poses.pop_front();
      fields(got, gf);
      fields(want, wf);
      for (int i = 0; i < 7; i++) begin
        if (gf[i] != wf[i]) begin
          report($sformatf("%s: got %0d, want %0d", names[i], gf[i], wf[i]));
        end
      end
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  bit             calm = 0;
  int             gap_odds = 0;
  int             quiet = 0;
  pose_scoreboard sb;

  pfc_cfg_if    cfg_ch();
  pfc_pose_if   pose_ch();
  pfc_result_if res_ch();

  pose_frame_convert_in_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .pose  (pose_ch),
    .result(res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic pose_item_t make_pose(int lx, int ly, int lz, int qx, int qy, int qz,
                                           int qw, logic dev);
    pose_item_t p;
    p.loc.x = lx;
    p.loc.y = ly;
    p.loc.z = lz;
    p.rot.x = 18'(qx);
    p.rot.y = 18'(qy);
    p.rot.z = 18'(qz);
    p.rot.w = 18'(qw);
    p.dev   = dev;
    return p;
  endfunction

  function automatic pose_item_t directed_pose(int k);
    case (k)
      0:  return make_pose(0, 0, 0, 0, 0, 0, 0, 1'b0);
      1:  return make_pose(100, -200, 300, 0, 0, 0, 65536, 1'b1);
      2:  return make_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           131071, 131071, 131071, 131071, 1'b1);
      3:  return make_pose(32'h80000000, 32'h80000000, 32'h80000000,
                           -131072, -131072, -131072, -131072, 1'b1);
      4:  return make_pose(50, -50, 150, 0, 0, 0, -65536, 1'b1);   // div ties
      5:  return make_pose(-150, 149, -149, 65536, 0, 0, 0, 1'b0);
      6:  return make_pose(-1, 1, 250, 0, 65536, 0, 0, 1'b1);
      7:  return make_pose(-250, 99, -99, 0, 0, 65536, 0, 1'b1);
      8:  return make_pose(32'h7FFFFFCE, 32'h80000032, -1,
                           -131072, 131071, -131072, 131071, 1'b0);
      9:  return make_pose(123456, -654321, 777, 23170, 0, 0, 46341, 1'b1);
      10: return make_pose(-98765, 4321, 50, 46341, -46341, 0, 0, 1'b1);
      default: return make_pose(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
                                131071, -131072, 32768, -32768, 1'b0);
    endcase
  endfunction

  function automatic int rand_loc();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 0;
        default: return -1;
      endcase
    end
    if (sel <= 3) return $urandom_range(0, 2000) - 1000;
    return $urandom;
  endfunction

  function automatic int rand_rot();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ($urandom_range(0, 1) == 0) ? 131071 : -131072;
    if (sel <= 6) return $urandom_range(0, 131072) - 65536;
    return $signed(18'($urandom));
  endfunction

  function automatic pose_item_t random_pose();
    return make_pose(rand_loc(), rand_loc(), rand_loc(), rand_rot(), rand_rot(), rand_rot(),
                     rand_rot(), 1'($urandom_range(0, 1)));
  endfunction

  task automatic program_reg(logic idx, logic [2:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_pose(pose_item_t p);
    @(negedge clk);
    pose_ch.valid       = 1'b1;
    pose_ch.loc_x       = p.loc.x;
    pose_ch.loc_y       = p.loc.y;
    pose_ch.loc_z       = p.loc.z;
    pose_ch.rot_x       = p.rot.x;
    pose_ch.rot_y       = p.rot.y;
    pose_ch.rot_z       = p.rot.z;
    pose_ch.rot_w       = p.rot.w;
    pose_ch.device_kind = p.dev;
    do @(posedge clk); while (!pose_ch.ready);
  endtask

  task automatic pose_idle();
    @(negedge clk);
    pose_ch.valid = 1'b0;
  endtask

  task automatic sender_gap();
    if (!calm && gap_odds != 0 && $urandom_range(1, 4) <= gap_odds) begin
      pose_idle();
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  endtask

  // hold the input idle until the pipeline is empty
  task automatic drain();
    pose_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : result_ready
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 10)) begin
          @(negedge clk);
          res_ch.ready = 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 30)) begin
          @(negedge clk);
          res_ch.ready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pose_item_t   seen;
    pose_result_t got;
    bit           busy;
    if (!rst) begin
      busy = 0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_reg(cfg_ch.index, cfg_ch.data);
        busy = 1;
      end
      if (pose_ch.valid && pose_ch.ready) begin
        seen = make_pose(pose_ch.loc_x, pose_ch.loc_y, pose_ch.loc_z, pose_ch.rot_x,
                         pose_ch.rot_y, pose_ch.rot_z, pose_ch.rot_w, pose_ch.device_kind);
        sb.note_pose(seen);
        busy = 1;
      end
      if (res_ch.valid && res_ch.ready) begin
        got.pos.x  = res_ch.pos_0;
        got.pos.y  = res_ch.pos_1;
        got.pos.z  = res_ch.pos_2;
        got.quat.x = res_ch.quat_x;
        got.quat.y = res_ch.quat_y;
        got.quat.z = res_ch.quat_z;
        got.quat.w = res_ch.quat_w;
        sb.check(got);
        busy = 1;
      end
      quiet = busy ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("pose_frame_convert_in_core verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sb = new();
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_SOURCE_RUNTIME;
    cfg_ch.data         = 3'd0;
    pose_ch.valid       = 1'b0;
    pose_ch.loc_x       = '0;
    pose_ch.loc_y       = '0;
    pose_ch.loc_z       = '0;
    pose_ch.rot_x       = '0;
    pose_ch.rot_y       = '0;
    pose_ch.rot_z       = '0;
    pose_ch.rot_w       = '0;
    pose_ch.device_kind = 1'b0;
    res_ch.ready        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: native frame with a controller fix, then a foreign frame without one
    program_reg(CFG_SOURCE_RUNTIME, 3'(RT_B));
    program_reg(CFG_TARGET_FRAME, 3'd0);
    for (int k = 0; k < 12; k++) send_pose(directed_pose(k));
    drain();
    program_reg(CFG_SOURCE_RUNTIME, 3'(RT_OPEN));
    program_reg(CFG_TARGET_FRAME, FRAME_FOREIGN_LAST);
    for (int k = 0; k < 12; k++) send_pose(directed_pose(k));
    drain();

    // every source/frame pair; upper data bit of the source register toggled at random
    for (int phase = 0; phase < 32; phase++) begin
      calm     = (phase >= 28);
      gap_odds = $urandom_range(0, 3);
      program_reg(CFG_SOURCE_RUNTIME, {1'($urandom_range(0, 1)), 2'(phase % 4)});
      program_reg(CFG_TARGET_FRAME, 3'(phase / 4));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_pose(random_pose());
        if (phase == 9 && k == 6) drain();
        sender_gap();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("pose_frame_convert_in_core verification clean");
    end else begin
      $display("pose_frame_convert_in_core verification failed");
    end
    $finish;
  end

endmodule
